/* src/srlr_pkg.sv */
// Shared types, constants and helper functions of the slow event reporter.
`timescale 1ns / 1ps
package srlr_pkg;

	localparam int unsigned TimeW      = 63;
	localparam int unsigned RegW       = 51;
	localparam int unsigned CountW     = 31;
	localparam int unsigned UsW        = 32;
	localparam int unsigned NumLanes   = 7;
	localparam int unsigned DiffW      = 64;
	localparam int unsigned DigitW     = 16;
	localparam int unsigned NumDigits  = DiffW / DigitW;
	localparam int unsigned RemW       = 10;
	localparam int unsigned DvdW       = RemW + DigitW;
	localparam int unsigned RecipW     = 27;
	localparam int unsigned ProdW      = DvdW + RecipW;
	localparam int unsigned RecipShift = 36;
	localparam int unsigned LaneStages = NumDigits + 2;
	localparam int unsigned PipeStages = LaneStages + 2;

	localparam int unsigned LaneEvRd = 0;
	localparam int unsigned LaneRdDl = 1;
	localparam int unsigned LaneDlCs = 2;
	localparam int unsigned LaneCsFn = 3;
	localparam int unsigned LaneCsGp = 4;
	localparam int unsigned LaneGpPr = 5;
	localparam int unsigned LaneEvPr = 6;

	localparam logic [RegW-1:0]   SlowThresholdRst = 51'd200000000;
	localparam logic [RegW-1:0]   MinIntervalRst   = 51'd60000000000;
	localparam logic [DvdW-1:0]   NsPerUs          = 26'd1000;
	localparam logic [RecipW-1:0] UsRecip          = 27'd68719477;
	localparam logic [CountW-1:0] CountMax         = '1;

	typedef enum logic [0:0] {
		CFG_SLOW_THRESHOLD = 1'b0,
		CFG_MIN_INTERVAL   = 1'b1
	} cfg_idx_t;

	typedef logic [TimeW-1:0] ns_t;

	typedef struct packed {
		logic is_down;
		logic complete;
		ns_t  pr;
		ns_t  gp;
		ns_t  fn;
		ns_t  cs;
		ns_t  dl;
		ns_t  rd;
		ns_t  ev;
	} item_t;

	typedef struct packed {
		logic              was_down;
		logic [CountW-1:0] events;
		logic [CountW-1:0] skipped;
	} meta_t;

	typedef logic [NumLanes-1:0][DiffW-1:0] diff_vec_t;

	typedef struct packed {
		logic [RemW-1:0]   rem;
		logic [DigitW-1:0] quo;
	} digit_t;

	function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
		return (c == CountMax) ? CountMax : c + {{(CountW-1){1'b0}}, 1'b1};
	endfunction

	// Divide the carried remainder and the next digit by 1000 with a scaled reciprocal.
	function automatic digit_t digit_div(input logic [RemW-1:0] rem,
			input logic [DigitW-1:0] dig);
		digit_t           o;
		logic [DvdW-1:0]  x;
		logic [ProdW-1:0] p;
		logic [DvdW-1:0]  back;
		x     = {rem, dig};
		p     = {{RecipW{1'b0}}, x} * {{DvdW{1'b0}}, UsRecip};
		o.quo = p[RecipShift +: DigitW];
		back  = x - {{RemW{1'b0}}, o.quo} * NsPerUs;
		o.rem = back[RemW-1:0];
		return o;
	endfunction

endpackage

/* src/slow_event_rate_limited_reporter.sv */
// Top level of the slow event rate-limited reporter.
// Throughput: one input transfer per cycle while m_tready back-pressure does not stall
// the pipeline; the decision and counter update are registered, and the conversion to
// microseconds runs as a 6-stage pipeline.
// Reset: thresholds return to defaults, counters and last report time clear,
// the pipeline empties; no clearing pass.
`timescale 1ns / 1ps
module slow_event_rate_limited_reporter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// event, read, delivery, consume, finish, gpu_done, present (63 bits each), pad
	input  logic [447:0]              s_tdata,
	// complete, is_down
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// read-event, delivery-read, consume-delivery, finish-consume, gpu-consume,
	// present-gpu, present-event latencies in us (32 bits each),
	// events_since_report, skipped_slow (31 bits each), pad
	output logic [287:0]              m_tdata,
	// was_down
	output logic [0:0]                m_tuser,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [srlr_pkg::RegW-1:0] cfg_wdata
);

	localparam int unsigned Last = srlr_pkg::PipeStages - 1;

	logic [srlr_pkg::PipeStages-1:0] vld_q;
	logic [srlr_pkg::PipeStages-1:0] en;
	srlr_pkg::item_t                 item_s1;
	logic                            report;
	srlr_pkg::diff_vec_t             diff_s2;
	srlr_pkg::meta_t                 meta_s2;
	srlr_pkg::meta_t                 meta_s [2:Last];
	logic signed [srlr_pkg::UsW-1:0] us_out [srlr_pkg::NumLanes];

	always_comb begin
		en[Last] = !vld_q[Last] || m_tready;
		for (int k = Last - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[Last];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			if (en[1]) begin
				vld_q[1] <= vld_q[0] && report;
			end
			for (int k = 2; k <= Last; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			item_s1.ev       <= s_tdata[62:0];
			item_s1.rd       <= s_tdata[125:63];
			item_s1.dl       <= s_tdata[188:126];
			item_s1.cs       <= s_tdata[251:189];
			item_s1.fn       <= s_tdata[314:252];
			item_s1.gp       <= s_tdata[377:315];
			item_s1.pr       <= s_tdata[440:378];
			item_s1.complete <= s_tuser[0];
			item_s1.is_down  <= s_tuser[1];
		end
	end

	srlr_gate u_gate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_s1),
		.valid     (vld_q[0]),
		.advance   (en[1]),
		.report    (report),
		.diff_s2   (diff_s2),
		.meta_s2   (meta_s2)
	);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			meta_s[2] <= meta_s2;
		end
		for (int k = 3; k <= Last; k++) begin
			if (en[k]) begin
				meta_s[k] <= meta_s[k-1];
			end
		end
	end

	for (genvar i = 0; i < srlr_pkg::NumLanes; i++) begin : g_lane
		srlr_us_conv u_conv (
			.clk  (clk),
			.en   (en[2 +: srlr_pkg::LaneStages]),
			.diff (diff_s2[i]),
			.us   (us_out[i])
		);
	end

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < srlr_pkg::NumLanes; i++) begin
			m_tdata[srlr_pkg::UsW*i +: srlr_pkg::UsW] = us_out[i];
		end
		m_tdata[srlr_pkg::NumLanes*srlr_pkg::UsW +: srlr_pkg::CountW] = meta_s[Last].events;
		m_tdata[srlr_pkg::NumLanes*srlr_pkg::UsW + srlr_pkg::CountW +: srlr_pkg::CountW] =
			meta_s[Last].skipped;
		m_tuser[0] = meta_s[Last].was_down;
	end

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld_q[0])
		else $error("input stage not ready while empty");

	a_report_counts: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[1] |-> (meta_s2.events != '0 && meta_s2.skipped <= meta_s2.events))
		else $error("report counts inconsistent");

	a_report_source: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[1] |-> $past(vld_q[0] || vld_q[1]))
		else $error("report stage filled without a record");

endmodule

/* src/srlr_gate.sv */
// Configuration registers, event and skip counters and the report decision.
`timescale 1ns / 1ps
module srlr_gate (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [srlr_pkg::RegW-1:0] cfg_wdata,
	input  srlr_pkg::item_t           item,
	input  logic                      valid,
	input  logic                      advance,
	output logic                      report,
	output srlr_pkg::diff_vec_t       diff_s2,
	output srlr_pkg::meta_t           meta_s2
);

	logic [srlr_pkg::RegW-1:0]   thr_q;
	logic [srlr_pkg::RegW-1:0]   intv_q;
	srlr_pkg::ns_t               last_q;
	logic [srlr_pkg::CountW-1:0] ev_cnt_q;
	logic [srlr_pkg::CountW-1:0] skip_cnt_q;

	logic [srlr_pkg::DiffW-1:0]  e2e;
	logic [srlr_pkg::DiffW-1:0]  elapsed;
	logic                        slow;
	logic                        too_soon;
	logic                        take;

	always_comb begin
		e2e      = {1'b0, item.pr} - {1'b0, item.ev};
		elapsed  = {1'b0, item.ev} - {1'b0, last_q};
		slow     = !e2e[srlr_pkg::DiffW-1] &&
			(e2e >= {{(srlr_pkg::DiffW-srlr_pkg::RegW){1'b0}}, thr_q});
		too_soon = elapsed[srlr_pkg::DiffW-1] ||
			(elapsed < {{(srlr_pkg::DiffW-srlr_pkg::RegW){1'b0}}, intv_q});
		report   = item.complete && slow && !too_soon;
		take     = valid && advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= srlr_pkg::SlowThresholdRst;
			intv_q     <= srlr_pkg::MinIntervalRst;
			last_q     <= '0;
			ev_cnt_q   <= '0;
			skip_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (srlr_pkg::cfg_idx_t'(cfg_index))
					srlr_pkg::CFG_SLOW_THRESHOLD: thr_q  <= cfg_wdata;
					srlr_pkg::CFG_MIN_INTERVAL:   intv_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (take && item.complete) begin
				if (report) begin
					ev_cnt_q   <= '0;
					skip_cnt_q <= '0;
					last_q     <= item.rd;
				end else begin
					ev_cnt_q <= srlr_pkg::sat_inc(ev_cnt_q);
					if (slow) begin
						skip_cnt_q <= srlr_pkg::sat_inc(skip_cnt_q);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			diff_s2[srlr_pkg::LaneEvRd] <= {1'b0, item.rd} - {1'b0, item.ev};
			diff_s2[srlr_pkg::LaneRdDl] <= {1'b0, item.dl} - {1'b0, item.rd};
			diff_s2[srlr_pkg::LaneDlCs] <= {1'b0, item.cs} - {1'b0, item.dl};
			diff_s2[srlr_pkg::LaneCsFn] <= {1'b0, item.fn} - {1'b0, item.cs};
			diff_s2[srlr_pkg::LaneCsGp] <= {1'b0, item.gp} - {1'b0, item.cs};
			diff_s2[srlr_pkg::LaneGpPr] <= {1'b0, item.pr} - {1'b0, item.gp};
			diff_s2[srlr_pkg::LaneEvPr] <= e2e;
			meta_s2.was_down <= item.is_down;
			meta_s2.events   <= srlr_pkg::sat_inc(ev_cnt_q);
			meta_s2.skipped  <= skip_cnt_q;
		end
	end

endmodule

/* src/srlr_us_conv.sv */
// Pipelined nanosecond to microsecond conversion of one signed difference.
`timescale 1ns / 1ps
module srlr_us_conv (
	input  logic                                clk,
	input  logic [srlr_pkg::LaneStages-1:0]     en,
	input  logic [srlr_pkg::DiffW-1:0]          diff,
	output logic signed [srlr_pkg::UsW-1:0]     us
);

	logic [srlr_pkg::DiffW-1:0] mag_s [srlr_pkg::NumDigits];
	logic [srlr_pkg::RemW-1:0]  rem_s [srlr_pkg::NumDigits];
	logic [srlr_pkg::UsW-1:0]   quo_s [srlr_pkg::NumDigits+1];
	logic                       neg_s [srlr_pkg::NumDigits+1];
	srlr_pkg::digit_t           dq    [1:srlr_pkg::NumDigits];
	logic [srlr_pkg::UsW-1:0]   us_q;

	always_comb begin
		for (int j = 1; j <= srlr_pkg::NumDigits; j++) begin
			dq[j] = srlr_pkg::digit_div(rem_s[j-1],
				mag_s[j-1][(srlr_pkg::NumDigits-j)*srlr_pkg::DigitW +: srlr_pkg::DigitW]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s[0] <= diff[srlr_pkg::DiffW-1];
			mag_s[0] <= diff[srlr_pkg::DiffW-1] ? (~diff + 64'd1) : diff;
			rem_s[0] <= '0;
			quo_s[0] <= '0;
		end
		for (int j = 1; j <= srlr_pkg::NumDigits; j++) begin
			if (en[j]) begin
				neg_s[j] <= neg_s[j-1];
				quo_s[j] <= {quo_s[j-1][srlr_pkg::UsW-srlr_pkg::DigitW-1:0], dq[j].quo};
			end
		end
		for (int j = 1; j < srlr_pkg::NumDigits; j++) begin
			if (en[j]) begin
				mag_s[j] <= mag_s[j-1];
				rem_s[j] <= dq[j].rem;
			end
		end
		if (en[srlr_pkg::LaneStages-1]) begin
			us_q <= neg_s[srlr_pkg::NumDigits] ?
				(~quo_s[srlr_pkg::NumDigits] + 32'd1) : quo_s[srlr_pkg::NumDigits];
		end
	end

	assign us = us_q;

endmodule

/* dv/slow_event_rate_limited_reporter_tb.sv */
// Self-checking testbench of the slow event rate-limited reporter: random and directed timelines.
`timescale 1ns / 1ps
module slow_event_rate_limited_reporter_tb;

	localparam int unsigned SettleCycles = 20;
	localparam int unsigned LongHold     = 400;
	localparam int unsigned CycleLimit   = 400000;
	localparam logic [63:0] TimeMax      = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] RegHigh      = 64'd2147483647000000;

	typedef enum int unsigned {
		REC_GOOD,
		REC_INCOMPLETE,
		REC_SCRAMBLED
	} rec_kind_t;

	typedef struct packed {
		logic                                               was_down;
		logic [srlr_pkg::CountW-1:0]                        skipped;
		logic [srlr_pkg::CountW-1:0]                        events;
		logic [srlr_pkg::NumLanes-1:0][srlr_pkg::UsW-1:0]   lat;
	} report_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [447:0]                  s_tdata   = '0;
	logic [1:0]                    s_tuser   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [287:0]                  m_tdata;
	logic [0:0]                    m_tuser;
	logic                          cfg_we    = 1'b0;
	logic [0:0]                    cfg_index = '0;
	logic [srlr_pkg::RegW-1:0]     cfg_wdata = '0;

	srlr_pkg::item_t               pending_recs [$];
	report_t                       expected_reports [$];

	logic [srlr_pkg::RegW-1:0]     mdl_threshold   = srlr_pkg::SlowThresholdRst;
	logic [srlr_pkg::RegW-1:0]     mdl_interval    = srlr_pkg::MinIntervalRst;
	logic [63:0]                   mdl_last_report = '0;
	logic [srlr_pkg::CountW-1:0]   mdl_events      = '0;
	logic [srlr_pkg::CountW-1:0]   mdl_skips       = '0;

	logic [63:0]        sim_now         = '0;
	int unsigned        send_idle_pct   = 0;
	int unsigned        recv_stall_pct  = 0;
	int unsigned        hold_reqs       = 0;
	int unsigned        hold_seen       = 0;
	int unsigned        hold_left       = 0;
	int unsigned        mismatch_count  = 0;
	int unsigned        cycle_count     = 0;

	string lane_names [srlr_pkg::NumLanes] = '{"ev_rd_us", "rd_dl_us",
		"dl_cs_us", "cs_fn_us", "cs_gp_us",
		"gp_pr_us", "ev_pr_us"};

	slow_event_rate_limited_reporter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [srlr_pkg::CountW-1:0] count_bump(
			input logic [srlr_pkg::CountW-1:0] c);
		return (c == {srlr_pkg::CountW{1'b1}}) ? c : c + 1'b1;
	endfunction

	function automatic bit under_limit(input logic [63:0] d,
			input logic [srlr_pkg::RegW-1:0] lim);
		return d[63] || (d < {13'd0, lim});
	endfunction

	function automatic logic [srlr_pkg::UsW-1:0] lat_us(
			input logic [srlr_pkg::TimeW-1:0] later,
			input logic [srlr_pkg::TimeW-1:0] earlier);
		logic [63:0] d;
		logic [63:0] mag;
		logic [63:0] q;
		d   = {1'b0, later} - {1'b0, earlier};
		mag = d[63] ? (64'd0 - d) : d;
		q   = mag / 64'd1000;
		if (d[63]) begin
			q = 64'd0 - q;
		end
		return q[srlr_pkg::UsW-1:0];
	endfunction

	function automatic bit predict_report(input srlr_pkg::item_t it, output report_t rep);
		logic [63:0] e2e;
		rep = '0;
		if (!it.complete) begin
			return 1'b0;
		end
		mdl_events = count_bump(mdl_events);
		e2e = {1'b0, it.pr} - {1'b0, it.ev};
		if (under_limit(e2e, mdl_threshold)) begin
			return 1'b0;
		end
		if (under_limit({1'b0, it.ev} - mdl_last_report, mdl_interval)) begin
			mdl_skips = count_bump(mdl_skips);
			return 1'b0;
		end
		rep.was_down                    = it.is_down;
		rep.lat[srlr_pkg::LaneEvRd]     = lat_us(it.rd, it.ev);
		rep.lat[srlr_pkg::LaneRdDl]     = lat_us(it.dl, it.rd);
		rep.lat[srlr_pkg::LaneDlCs]     = lat_us(it.cs, it.dl);
		rep.lat[srlr_pkg::LaneCsFn]     = lat_us(it.fn, it.cs);
		rep.lat[srlr_pkg::LaneCsGp]     = lat_us(it.gp, it.cs);
		rep.lat[srlr_pkg::LaneGpPr]     = lat_us(it.pr, it.gp);
		rep.lat[srlr_pkg::LaneEvPr]     = lat_us(it.pr, it.ev);
		rep.events                      = mdl_events;
		rep.skipped                     = mdl_skips;
		mdl_events                      = '0;
		mdl_skips                       = '0;
		mdl_last_report                 = {1'b0, it.rd};
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// drive the input side; hold the item until its transfer
	always @(posedge clk) begin
		srlr_pkg::item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_recs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				it = pending_recs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {7'd0, it[440:0]};
				s_tuser  <= it[442:441];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= LongHold;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		srlr_pkg::item_t acc;
		report_t         want;
		report_t         got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				acc = {s_tuser, s_tdata[440:0]};
				if (predict_report(acc, want)) begin
					expected_reports.insert(expected_reports.size(), want);
				end
			end
			if (m_tvalid && m_tready) begin
				got = {m_tuser[0], m_tdata[285:0]};
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf("report transfer with none expected, ev_pr_us %0d",
						$signed(got.lat[srlr_pkg::LaneEvPr])));
				end else begin
					want = expected_reports.pop_front();
					if (got.was_down !== want.was_down) begin
						report_mismatch($sformatf("was_down got %0d want %0d",
							got.was_down, want.was_down));
					end
					for (int k = 0; k < srlr_pkg::NumLanes; k++) begin
						if (got.lat[k] !== want.lat[k]) begin
							report_mismatch($sformatf("%s got %0d want %0d", lane_names[k],
								$signed(got.lat[k]), $signed(want.lat[k])));
						end
					end
					if (got.events !== want.events) begin
						report_mismatch($sformatf("events_since_report got %0d want %0d",
							got.events, want.events));
					end
					if (got.skipped !== want.skipped) begin
						report_mismatch($sformatf("skipped_slow got %0d want %0d",
							got.skipped, want.skipped));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_recs.size() != 0 || s_tvalid || expected_reports.size() != 0) begin
			@(negedge clk);
		end
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_reg(input srlr_pkg::cfg_idx_t idx,
			input logic [srlr_pkg::RegW-1:0] val);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == srlr_pkg::CFG_SLOW_THRESHOLD) begin
			mdl_threshold = val;
		end else begin
			mdl_interval = val;
		end
	endtask

	task automatic set_regs(input logic [63:0] thr, input logic [63:0] ivl);
		write_reg(srlr_pkg::CFG_SLOW_THRESHOLD, thr[srlr_pkg::RegW-1:0]);
		write_reg(srlr_pkg::CFG_MIN_INTERVAL, ivl[srlr_pkg::RegW-1:0]);
	endtask

	task automatic push_rec(input logic [63:0] ev, input logic [63:0] rd, input logic [63:0] dl,
			input logic [63:0] cs, input logic [63:0] fn, input logic [63:0] gp,
			input logic [63:0] pr, input logic complete, input logic is_down);
		srlr_pkg::item_t it;
		it.ev       = ev[srlr_pkg::TimeW-1:0];
		it.rd       = rd[srlr_pkg::TimeW-1:0];
		it.dl       = dl[srlr_pkg::TimeW-1:0];
		it.cs       = cs[srlr_pkg::TimeW-1:0];
		it.fn       = fn[srlr_pkg::TimeW-1:0];
		it.gp       = gp[srlr_pkg::TimeW-1:0];
		it.pr       = pr[srlr_pkg::TimeW-1:0];
		it.complete = complete;
		it.is_down  = is_down;
		pending_recs.insert(pending_recs.size(), it);
	endtask

	// build one timeline around the current threshold and interval
	task automatic push_timeline(input rec_kind_t kind);
		logic [63:0] thr;
		logic [63:0] ivl;
		logic [63:0] e2e;
		logic [63:0] ev;
		logic [63:0] rd;
		logic [63:0] dl;
		logic [63:0] cs;
		logic [63:0] fn;
		logic [63:0] gp;
		logic [63:0] pr;
		logic [63:0] junk;
		logic [31:0] r;
		thr = {13'd0, mdl_threshold};
		ivl = {13'd0, mdl_interval};
		r   = $urandom;
		if ({1'b0, mdl_last_report[62:0]} > sim_now) begin
			sim_now = {1'b0, mdl_last_report[62:0]};
		end
		sim_now = sim_now + rand64() % (ivl + ivl + 64'd1) + {44'd0, r[19:0]};
		case (r[21:20])
			2'd0:    e2e = rand64() % (thr + 64'd1);
			2'd1:    e2e = thr;
			default: e2e = thr + rand64() % (thr + 64'd5000000000);
		endcase
		ev   = {1'b0, sim_now[62:0]};
		pr   = ev + e2e;
		rd   = ev + rand64() % (e2e / 64'd4 + 64'd1);
		dl   = rd + rand64() % (pr - rd + 64'd1);
		cs   = dl + rand64() % (pr - dl + 64'd1);
		gp   = cs + rand64() % (pr - cs + 64'd1);
		fn   = cs + rand64() % (e2e + 64'd1);
		junk = rand64();
		if (kind == REC_SCRAMBLED) begin
			case ($urandom_range(6))
				0:       ev = junk;
				1:       rd = junk;
				2:       dl = junk;
				3:       cs = junk;
				4:       fn = junk;
				5:       gp = junk;
				default: pr = junk;
			endcase
		end
		push_rec(ev, rd, dl, cs, fn, gp, pr, kind != REC_INCOMPLETE, r[22]);
	endtask

	task automatic push_random(input int n);
		logic [31:0] r;
		for (int i = 0; i < n; i++) begin
			while (pending_recs.size() > 3) begin
				@(negedge clk);
			end
			r = $urandom_range(99);
			if (r < 70) begin
				push_timeline(REC_GOOD);
			end else if (r < 82) begin
				push_timeline(REC_INCOMPLETE);
			end else if (r < 94) begin
				push_timeline(REC_SCRAMBLED);
			end else begin
				r = $urandom;
				push_rec(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
					r[0], r[1]);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset thresholds: ignored, fast, skipped, reported, boundaries, backwards times
		push_rec(0, 0, 0, 0, 0, 0, 64'd500000000, 1'b0, 1'b1);
		push_rec(1000, 2000, 3000, 4000, 5000, 6000, 7000, 1'b1, 1'b0);
		push_rec(64'd1000000000, 64'd1000100000, 64'd1000200000, 64'd1000300000,
			64'd1000400000, 64'd1000500000, 64'd1300000000, 1'b1, 1'b0);
		push_rec(64'd70000000000, 64'd70000001500, 64'd70000250000, 64'd70002500000,
			64'd70100000000, 64'd70200000000, 64'd70250000000, 1'b1, 1'b1);
		push_rec(64'd130000001500, 64'd130000002499, 64'd130000003499, 64'd130000004500,
			64'd130000005000, 64'd130000006000, 64'd130200001500, 1'b1, 1'b0);
		push_rec(64'd300000000000, 64'd300000000001, 64'd300000000002, 64'd300000000003,
			64'd300000000004, 64'd300000000005, 64'd300199999999, 1'b1, 1'b1);
		push_rec(64'd500000000000, 64'd400000000000, 64'd300000000000, 64'd200000000000,
			64'd100000000000, 64'd100000000, 1000, 1'b1, 1'b0);
		push_rec(0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0);
		push_rec(0, TimeMax, TimeMax, TimeMax, TimeMax, TimeMax, TimeMax, 1'b1, 1'b1);
		push_rec(TimeMax - 64'd300000000, 0, TimeMax, 0, TimeMax, 0, TimeMax, 1'b1, 1'b1);
		push_rec(64'd59999999999, 64'd60000000000, 64'd60000000001, 64'd60000000002,
			64'd60000000003, 64'd60000000004, 64'd60299999999, 1'b1, 1'b0);

		// zero threshold and interval: zero latency is slow, negative elapsed still skips
		set_regs(0, 0);
		push_rec(0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
		push_rec(TimeMax, TimeMax, TimeMax, TimeMax, TimeMax, TimeMax, TimeMax, 1'b1, 1'b0);
		push_rec(5, 5, 5, 5, 5, 5, 5, 1'b1, 1'b1);
		push_rec(10, 10, 10, 10, 10, 10, 9, 1'b1, 1'b0);
		push_rec(TimeMax, TimeMax - 64'd999, TimeMax - 64'd1999, TimeMax - 64'd998,
			TimeMax - 64'd2997, TimeMax - 64'd1003, TimeMax, 1'b1, 1'b1);
		push_rec(TimeMax, 0, 0, 0, 0, 0, TimeMax, 1'b1, 1'b0);
		push_random(100);

		// stall the output for a long stretch while transfers keep coming
		wait_drained();
		push_rec(TimeMax, 0, 0, 0, 0, 0, TimeMax, 1'b1, 1'b0);
		hold_reqs++;
		for (int i = 0; i < 60; i++) begin
			sim_now = sim_now + 64'd2000000000;
			push_rec(sim_now, sim_now + 64'd1000, sim_now + 64'd2500, sim_now + 64'd4000,
				sim_now + 64'd6000, sim_now + 64'd7000, sim_now + 64'd9000, 1'b1, i[0]);
		end
		wait_drained();
		push_random(40);

		set_regs(RegHigh, RegHigh);
		send_idle_pct  = 87;
		recv_stall_pct = 0;
		push_random(110);

		set_regs(rand64() % (RegHigh + 64'd1), rand64() % (RegHigh + 64'd1));
		send_idle_pct  = 0;
		recv_stall_pct = 87;
		push_random(110);

		set_regs({13'd0, srlr_pkg::SlowThresholdRst}, {13'd0, srlr_pkg::MinIntervalRst});
		send_idle_pct  = 17;
		recv_stall_pct = 17;
		push_random(110);

		set_regs(RegHigh, 0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		push_random(60);

		set_regs(0, RegHigh);
		send_idle_pct  = 17;
		recv_stall_pct = 17;
		push_random(60);

		wait_drained();
		if (mismatch_count == 0 && expected_reports.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* slow_event_rate_limited_reporter.f */
src/srlr_pkg.sv
src/srlr_gate.sv
src/srlr_us_conv.sv
src/slow_event_rate_limited_reporter.sv
dv/slow_event_rate_limited_reporter_tb.sv
